/* design/sobel_edge_threshold_stream_top_macros.svh */
// ----------------------------------------------------------------------------
// Sobel edge stream assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_STREAM_TOP_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_STREAM_TOP_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define SOBEL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SOBEL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/sobel_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel edge stream package
// Types, constants and helper functions shared by the edge detector modules.
// ----------------------------------------------------------------------------
package sobel_pkg;

    // Frame geometry limits and derived counter widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field widths fixed by the interface.
    localparam int GREY_W     = 8;
    localparam int COORD_W    = 11;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int THR_W      = 11;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST    = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST   = 12'd480;
    localparam logic [THR_W-1:0]      EDGE_THRESHOLD_RST = 11'd160;

    // Divide by three as a multiply by 683 and a shift by 11; exact for sums below 2048.
    localparam int SUM_W       = GREY_W + 2;
    localparam int PROD_W      = 2 * SUM_W;
    localparam int GREY_RECIP  = 683;
    localparam int GREY_SHIFT  = 11;

    // Gradient arithmetic widths.
    localparam int GRAD_W = 11;
    localparam int ABS_W  = 10;

    localparam logic [GREY_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [GREY_W-1:0] EDGE_OFF = 8'd0;

    // Queue depths, powers of two.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 8;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    // Result slots of one pixel, in emission order.
    localparam int RES_A = 0;
    localparam int RES_B = 1;
    localparam int RES_C = 2;
    localparam int RES_N = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic [GREY_W-1:0]  edge_pixel;
        logic               last_of_run;
    } result_t;

    // One classified pixel handed from the front part to the back part.
    typedef struct packed {
        logic [GREY_W-1:0] grey;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [RES_N-1:0]  emit;
        logic              interior;
    } cmd_t;

    // One entry of the result queue: up to three results of one pixel.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [RES_N-1:0] emit;
        logic             edge_hit;
    } res_entry_t;

    function automatic logic signed [GRAD_W:0] grey_ext(input logic [GREY_W-1:0] v);
        return $signed({{(GRAD_W + 1 - GREY_W){1'b0}}, v});
    endfunction

endpackage

/* design/sobel_ram.sv */
// ----------------------------------------------------------------------------
// Sobel generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sobel_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/sobel_front.sv */
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, converts them to grey and tags each with its position and
// the results it will cause.
// ----------------------------------------------------------------------------
module sobel_front import sobel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_t                s_data,
    input  logic [CFG_DATA_W-1:0] frame_width,
    input  logic [CFG_DATA_W-1:0] frame_height,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W:0]    w_eff, x_inc;
    logic [ROW_W:0]    h_eff, y_inc;
    logic              last_col, last_row;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        if (frame_width == '0) begin
            w_eff = (COL_W + 1)'(1);
        end else if (int'(frame_width) > MAX_WIDTH) begin
            w_eff = (COL_W + 1)'(MAX_WIDTH);
        end else begin
            w_eff = (COL_W + 1)'(frame_width);
        end
        if (frame_height == '0) begin
            h_eff = (ROW_W + 1)'(1);
        end else if (int'(frame_height) > MAX_HEIGHT) begin
            h_eff = (ROW_W + 1)'(MAX_HEIGHT);
        end else begin
            h_eff = (ROW_W + 1)'(frame_height);
        end
    end

    assign x_inc    = {1'b0, col_reg} + 1'b1;
    assign y_inc    = {1'b0, row_reg} + 1'b1;
    assign last_col = (x_inc >= w_eff);
    assign last_row = (y_inc >= h_eff);

    assign sum  = {2'b00, s_data.red} + {2'b00, s_data.green} + {2'b00, s_data.blue};
    assign prod = PROD_W'(sum) * PROD_W'(GREY_RECIP);

    always_comb begin
        q_cmd.grey         = prod[GREY_SHIFT +: GREY_W];
        q_cmd.col          = col_reg;
        q_cmd.row          = row_reg;
        q_cmd.emit[RES_A]  = (col_reg != '0) && (row_reg != '0);
        q_cmd.emit[RES_B]  = last_col && (row_reg != '0);
        q_cmd.emit[RES_C]  = last_row;
        // The window center is one column left and one row up of this pixel.
        q_cmd.interior     = (col_reg >= COL_W'(2)) && ({1'b0, col_reg} < w_eff) &&
                             (row_reg >= ROW_W'(2)) && ({1'b0, row_reg} < h_eff);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : y_inc[ROW_W-1:0];
            end else begin
                col_next = x_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* design/sobel_cmd_queue.sv */
// ----------------------------------------------------------------------------
// Sobel command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module sobel_cmd_queue import sobel_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t               mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* design/sobel_back.sv */
// ----------------------------------------------------------------------------
// Sobel back end
// Runs the line stores and the 3x3 window, computes the gradient, and sends
// the results of each pixel out one transfer at a time.
// ----------------------------------------------------------------------------
module sobel_back import sobel_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  cmd_t             q_head,
    output logic             q_pop,
    input  logic [THR_W-1:0] edge_threshold,
    output logic             m_valid,
    input  logic             m_ready,
    output result_t          m_data,
    output logic [RESQ_CW:0] inflight
);

    // Read stage: line store data is registered and returns in the cycle after the pop.
    logic              ex_valid_reg;
    cmd_t              ex_cmd_reg;
    logic              fwd_hit_reg;
    logic [GREY_W-1:0] fwd_upper_reg, fwd_middle_reg;
    logic [GREY_W-1:0] upper_q, middle_q, upper_rd, middle_rd;
    logic [GREY_W-1:0] window_reg [9];

    // Gradient and threshold stages.
    logic                    gr_valid_reg, th_valid_reg;
    cmd_t                    gr_cmd_reg, th_cmd_reg;
    logic signed [GRAD_W:0]  gx, gy;
    logic [ABS_W-1:0]        abs_gx_reg, abs_gy_reg;
    logic [THR_W-1:0]        mag;

    // Result queue and output sequencer.
    res_entry_t          rq_mem_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0]  rq_wr_ptr_reg, rq_rd_ptr_reg;
    logic [RESQ_CW-1:0]  rq_count_reg, rq_count_next;
    logic                rq_push, rq_pop;
    res_entry_t          rq_head;
    logic [RES_N-1:0]    done_reg, done_next, remain, sel, rest;
    logic                m_valid_reg, m_valid_next;
    result_t             m_data_reg, m_data_next;

    // Items between the pop and the result queue are counted against its free space.
    assign inflight = (RESQ_CW + 1)'(ex_valid_reg) + (RESQ_CW + 1)'(gr_valid_reg) +
                      (RESQ_CW + 1)'(th_valid_reg) + (RESQ_CW + 1)'(rq_count_reg);
    assign q_pop    = !q_empty && (inflight < (RESQ_CW + 1)'(RESQ_DEPTH));

    sobel_ram #(.WIDTH(GREY_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .aclk  (aclk),
        .we    (ex_valid_reg),
        .waddr (ex_cmd_reg.col),
        .wdata (middle_rd),
        .re    (q_pop),
        .raddr (q_head.col),
        .rdata (upper_q)
    );

    sobel_ram #(.WIDTH(GREY_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .aclk  (aclk),
        .we    (ex_valid_reg),
        .waddr (ex_cmd_reg.col),
        .wdata (ex_cmd_reg.grey),
        .re    (q_pop),
        .raddr (q_head.col),
        .rdata (middle_q)
    );

    // A read issued while the previous item writes the same column sees old
    // data, so the values being written are forwarded instead.
    assign upper_rd  = fwd_hit_reg ? fwd_upper_reg  : upper_q;
    assign middle_rd = fwd_hit_reg ? fwd_middle_reg : middle_q;

    always_ff @(posedge aclk) begin
        ex_cmd_reg     <= q_head;
        fwd_upper_reg  <= middle_rd;
        fwd_middle_reg <= ex_cmd_reg.grey;
        gr_cmd_reg     <= ex_cmd_reg;
        th_cmd_reg     <= gr_cmd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            gr_valid_reg <= 1'b0;
            th_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            ex_valid_reg <= q_pop;
            gr_valid_reg <= ex_valid_reg;
            th_valid_reg <= gr_valid_reg;
            fwd_hit_reg  <= q_pop && ex_valid_reg && (q_head.col == ex_cmd_reg.col);
            if (ex_valid_reg) begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= upper_rd;
                window_reg[3] <= window_reg[4];
                window_reg[4] <= window_reg[5];
                window_reg[5] <= middle_rd;
                window_reg[6] <= window_reg[7];
                window_reg[7] <= window_reg[8];
                window_reg[8] <= ex_cmd_reg.grey;
            end
        end
    end

    always_comb begin
        gx = (grey_ext(window_reg[0]) - grey_ext(window_reg[2])) +
             ((grey_ext(window_reg[3]) - grey_ext(window_reg[5])) <<< 1) +
             (grey_ext(window_reg[6]) - grey_ext(window_reg[8]));
        gy = (grey_ext(window_reg[0]) + (grey_ext(window_reg[1]) <<< 1) +
              grey_ext(window_reg[2])) -
             (grey_ext(window_reg[6]) + (grey_ext(window_reg[7]) <<< 1) +
              grey_ext(window_reg[8]));
    end

    always_ff @(posedge aclk) begin
        abs_gx_reg <= gx[GRAD_W] ? ABS_W'(-gx) : ABS_W'(gx);
        abs_gy_reg <= gy[GRAD_W] ? ABS_W'(-gy) : ABS_W'(gy);
    end

    assign mag     = {1'b0, abs_gx_reg} + {1'b0, abs_gy_reg};
    assign rq_push = th_valid_reg;
    assign rq_head = rq_mem_reg[rq_rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (rq_push) begin
            rq_mem_reg[rq_wr_ptr_reg].col      <= th_cmd_reg.col;
            rq_mem_reg[rq_wr_ptr_reg].row      <= th_cmd_reg.row;
            rq_mem_reg[rq_wr_ptr_reg].emit     <= th_cmd_reg.emit;
            rq_mem_reg[rq_wr_ptr_reg].edge_hit <= th_cmd_reg.interior &&
                                                  (mag > edge_threshold);
        end
    end

    always_comb begin
        rq_count_next = rq_count_reg;
        if (rq_push && !rq_pop) begin
            rq_count_next = rq_count_reg + 1'b1;
        end else if (rq_pop && !rq_push) begin
            rq_count_next = rq_count_reg - 1'b1;
        end
    end

    // Each queue entry yields its pending results lowest slot first; an entry
    // with none is dropped without producing a transfer.
    always_comb begin
        remain       = rq_head.emit & ~done_reg;
        sel          = remain & (~remain + 1'b1);
        rest         = remain & ~sel;
        rq_pop       = 1'b0;
        done_next    = done_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if ((rq_count_reg != '0) && (!m_valid_reg || m_ready)) begin
            if (remain == '0) begin
                rq_pop    = 1'b1;
                done_next = '0;
            end else begin
                m_valid_next            = 1'b1;
                m_data_next.last_of_run = (rest == '0);
                if (sel[RES_A]) begin
                    m_data_next.out_column = COORD_W'(rq_head.col - 1'b1);
                    m_data_next.out_row    = COORD_W'(rq_head.row - 1'b1);
                    m_data_next.edge_pixel = rq_head.edge_hit ? EDGE_ON : EDGE_OFF;
                end else if (sel[RES_B]) begin
                    m_data_next.out_column = COORD_W'(rq_head.col);
                    m_data_next.out_row    = COORD_W'(rq_head.row - 1'b1);
                    m_data_next.edge_pixel = EDGE_OFF;
                end else begin
                    m_data_next.out_column = COORD_W'(rq_head.col);
                    m_data_next.out_row    = COORD_W'(rq_head.row);
                    m_data_next.edge_pixel = EDGE_OFF;
                end
                if (rest == '0) begin
                    rq_pop    = 1'b1;
                    done_next = '0;
                end else begin
                    done_next = done_reg | sel;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_count_reg  <= '0;
            done_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (rq_push) begin
                rq_wr_ptr_reg <= rq_wr_ptr_reg + 1'b1;
            end
            if (rq_pop) begin
                rq_rd_ptr_reg <= rq_rd_ptr_reg + 1'b1;
            end
            rq_count_reg <= rq_count_next;
            done_reg     <= done_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/sobel_edge_threshold_stream_top.sv */
// ----------------------------------------------------------------------------
// Sobel edge threshold stream, top level
// Streaming 3x3 Sobel edge detector with threshold and per-result coordinates.
// ----------------------------------------------------------------------------
// RGB pixels enter in raster order, one per clock when the result side keeps
// up; each becomes grey, passes a 3x3 Sobel window fed by two line stores
// (two 2048 x 8 RAMs, one read and one write per clock, no clearing pass
// after reset), and leaves as 255 or 0 with its column and row. Results leave
// at one transfer per clock while m_ready is high; a pixel in the last column
// or last row can cause up to three results and holds the result side while
// they leave, which limits the sustained rate. A pixel's first result passes
// the command queue and the read, gradient, threshold, result queue and output
// stages before m_valid rises. The user writes geometry and threshold through
// the configuration port only while the stream is idle; it is not enforced.
// ----------------------------------------------------------------------------
`include "sobel_edge_threshold_stream_top_macros.svh"

module sobel_edge_threshold_stream_top import sobel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_t                s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [CFG_DATA_W-1:0] frame_width_reg, frame_height_reg;
    logic [THR_W-1:0]      edge_threshold_reg;
    logic                  q_push, q_pop, q_full, q_empty;
    cmd_t                  q_cmd, q_head;
    logic [RESQ_CW:0]      back_inflight;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wr_data;
                end
                CFG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wr_data;
                end
                CFG_EDGE_THRESHOLD: begin
                    edge_threshold_reg <= cfg_wr_data[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sobel_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    sobel_cmd_queue u_cmd_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    sobel_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .edge_threshold (edge_threshold_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .inflight       (back_inflight)
    );

    `SOBEL_ASSERT_ALWAYS(a_result_credit, back_inflight <= (RESQ_CW + 1)'(RESQ_DEPTH),
        "result queue credit overrun")
    `SOBEL_ASSERT_IMPLY(a_border_no_edge, m_valid && (m_data.edge_pixel != EDGE_OFF),
        (m_data.out_column != '0) && (m_data.out_row != '0), "edge reported on border pixel")
    `SOBEL_ASSERT_IMPLY(a_edge_code, m_valid,
        (m_data.edge_pixel == EDGE_ON) || (m_data.edge_pixel == EDGE_OFF),
        "edge value is neither 0 nor 255")

endmodule
